// ----- sv/tcpq_pkg.sv -----
`default_nettype none

package tcpq_pkg;

    // queue geometry
    localparam int DEPTH  = 16;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int MAXRES = 16;
    localparam int LW     = $clog2(MAXRES + 1);
    localparam int OW     = 5;
    localparam int NW     = (CW > LW) ? ((CW > OW) ? CW : OW) : ((LW > OW) ? LW : OW);

    // field widths
    localparam int TW  = 16;
    localparam int AW  = 7;
    localparam int ACW = 3;
    localparam int SW  = 2;
    localparam int LMW = 5;
    localparam int CIW = 2;
    localparam int CDW = 7;

    // register reset values
    localparam logic [AW-1:0]  SENIOR_RST = AW'(60);
    localparam logic [LMW-1:0] LIMIT_RST  = LMW'(5);

    // action codes
    localparam logic [ACW-1:0] ACT_ENQ     = 3'd0;
    localparam logic [ACW-1:0] ACT_DEQ     = 3'd1;
    localparam logic [ACW-1:0] ACT_SERVE   = 3'd2;
    localparam logic [ACW-1:0] ACT_PROMOTE = 3'd3;
    localparam logic [ACW-1:0] ACT_ALL     = 3'd4;

    // status codes
    localparam logic [SW-1:0] ST_OK       = 2'd0;
    localparam logic [SW-1:0] ST_EMPTY    = 2'd1;
    localparam logic [SW-1:0] ST_FULL     = 2'd2;
    localparam logic [SW-1:0] ST_NOTFOUND = 2'd3;

    // configuration register indexes
    localparam logic [CIW-1:0] CFG_SENIOR = 2'd0;
    localparam logic [CIW-1:0] CFG_LIMIT  = 2'd1;

    // broadcast command to the cell row
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS,
        OP_POP,
        OP_MARK_ALL,
        OP_MARK_HEAD,
        OP_START,
        OP_SCAN,
        OP_SWAP
    } t_op;

    typedef struct packed {
        logic          vld;
        logic          prio;
        logic [TW-1:0] tkt;
        logic [AW-1:0] age;
    } t_ent;

    typedef struct packed {
        t_op           op;
        logic          ins_prio;
        t_ent          ent;
        logic [TW-1:0] key;
    } t_ctl;

    // summary of the row seen by the controller
    typedef struct packed {
        t_ent head;
        logic hit;
        logic stop;
        logic tok0;
    } t_row_st;

endpackage

`default_nettype wire

// ----- sv/tcpq_cell.sv -----
`default_nettype none

module tcpq_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_first,
    input  wire tcpq_pkg::t_ctl  i_ctl,
    input  wire tcpq_pkg::t_ent  i_left,
    input  wire tcpq_pkg::t_ent  i_right,
    input  wire logic            i_left_shift,
    input  wire logic            i_left_tok,
    input  wire logic            i_right_tok,
    output tcpq_pkg::t_ent       o_ent,
    output logic                 o_shift,
    output logic                 o_tok,
    output logic                 o_hit,
    output logic                 o_tok_empty
);
    import tcpq_pkg::*;

    logic          r_vld, r_prio, r_tok;
    logic [TW-1:0] r_tkt;
    logic [AW-1:0] r_age;
    t_ent          w_ent, n_ent;
    logic          n_tok;

    assign w_ent = '{vld: r_vld, prio: r_prio, tkt: r_tkt, age: r_age};

    // this cell sits at or behind the insert point
    assign o_shift = !(r_vld && (i_ctl.ins_prio ? r_prio : 1'b1));

    // next contents from the broadcast command and the neighbors
    always_comb begin
        n_ent = w_ent;
        n_tok = r_tok;
        unique case (i_ctl.op)
            OP_INS: begin
                if (o_shift) begin
                    n_ent = i_left_shift ? i_left : i_ctl.ent;
                end
            end
            OP_POP:       n_ent = i_right;
            OP_MARK_ALL:  n_ent.prio = 1'b1;
            OP_MARK_HEAD: begin
                if (i_first) begin
                    n_ent.prio = 1'b1;
                end
            end
            OP_START:     n_tok = i_first;
            OP_SCAN:      n_tok = i_left_tok;
            OP_SWAP: begin
                if (r_tok) begin
                    n_ent = i_left;
                end else if (i_right_tok) begin
                    n_ent = i_right;
                end
                n_tok = i_right_tok;
            end
            OP_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // occupancy, mark and search token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_prio <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_vld  <= n_ent.vld;
            r_prio <= n_ent.prio;
            r_tok  <= n_tok;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        r_tkt <= n_ent.tkt;
        r_age <= n_ent.age;
    end

    assign o_ent       = w_ent;
    assign o_tok       = r_tok;
    assign o_hit       = r_tok && r_vld && (r_tkt == i_ctl.key);
    assign o_tok_empty = r_tok && !r_vld;

endmodule

`default_nettype wire

// ----- sv/tcpq_row.sv -----
`default_nettype none

module tcpq_row (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tcpq_pkg::t_ctl   i_ctl,
    output tcpq_pkg::t_row_st     o_st
);
    import tcpq_pkg::*;

    t_ent [DEPTH-1:0] w_ent;
    logic [DEPTH-1:0] w_shift, w_tok, w_hit, w_tok_empty;

    // row of cells, each wired to both neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_ent w_l, w_r;
        logic w_lsh, w_ltok, w_rtok;
        if (g == 0) begin : g_head
            assign w_l    = '0;
            assign w_lsh  = 1'b0;
            assign w_ltok = 1'b0;
        end else begin : g_mid
            assign w_l    = w_ent[g-1];
            assign w_lsh  = w_shift[g-1];
            assign w_ltok = w_tok[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_r    = '0;
            assign w_rtok = 1'b0;
        end else begin : g_body
            assign w_r    = w_ent[g+1];
            assign w_rtok = w_tok[g+1];
        end
        tcpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_first      ((g == 0) ? 1'b1 : 1'b0),
            .i_ctl        (i_ctl),
            .i_left       (w_l),
            .i_right      (w_r),
            .i_left_shift (w_lsh),
            .i_left_tok   (w_ltok),
            .i_right_tok  (w_rtok),
            .o_ent        (w_ent[g]),
            .o_shift      (w_shift[g]),
            .o_tok        (w_tok[g]),
            .o_hit        (w_hit[g]),
            .o_tok_empty  (w_tok_empty[g])
        );
    end

    // search outcome: match under the token, or token reached an empty cell or the last cell
    assign o_st.head = w_ent[0];
    assign o_st.hit  = |w_hit;
    assign o_st.stop = (|w_tok_empty) || w_tok[DEPTH-1];
    assign o_st.tok0 = w_tok[0];

endmodule

`default_nettype wire

// ----- sv/two_class_priority_queue.sv -----
`default_nettype none

// Two-class queue of tickets held in a row of cells, priority entries first.
// Command channel (i_cmd_valid / o_cmd_ready) takes one action per transfer:
// enqueue, dequeue, serve batch, promote ticket, promote all. Each command
// yields one result on the result channel (o_res_valid / i_res_ready),
// except a serve, which yields one result per popped entry with o_last on
// the final one. Configuration writes use i_cfg_valid / o_cfg_ready, index 0
// senior age, index 1 serve limit, and are taken in every cycle.
// Enqueue, promote all and refused or empty commands give their result in the
// cycle after the transfer. Dequeue and serve first enter the pop state, which
// registers one popped entry per cycle as a result while the receiver takes
// them. Promote ticket walks a token one cell per cycle from the head to the
// match, then swaps the entry one cell per cycle back to the head.
// A new command is taken once the previous one has finished and the result
// register is free. A stalled receiver holds the result and pauses a serve.
// Reset empties the queue and loads senior age 60 and serve limit 5.

module two_class_priority_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cmd_valid,
    output logic                          o_cmd_ready,
    input  wire logic [tcpq_pkg::ACW-1:0] i_action,
    input  wire logic [tcpq_pkg::TW-1:0]  i_ticket,
    input  wire logic [tcpq_pkg::AW-1:0]  i_age,
    input  wire logic                     i_health_worker,
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output logic [tcpq_pkg::SW-1:0]       o_status,
    output logic                          o_out_valid,
    output logic [tcpq_pkg::TW-1:0]       o_out_ticket,
    output logic [tcpq_pkg::AW-1:0]       o_out_age,
    output logic                          o_out_priority,
    output logic                          o_last,
    output logic [tcpq_pkg::OW-1:0]       o_occupancy,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [tcpq_pkg::CIW-1:0] i_cfg_index,
    input  wire logic [tcpq_pkg::CDW-1:0] i_cfg_data
);
    import tcpq_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_POP, S_SCAN, S_BUBBLE} t_state;

    typedef struct packed {
        logic [SW-1:0] status;
        logic          ovld;
        logic [TW-1:0] tkt;
        logic [AW-1:0] age;
        logic          prio;
        logic          last;
        logic [OW-1:0] occ;
    } t_res;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_fill, n_fill;
    logic [LW-1:0]  r_left, n_left;
    logic [TW-1:0]  r_key, n_key;
    logic           r_rvld, n_rvld;
    t_res           r_res, n_res;
    logic [AW-1:0]  r_senior;
    logic [LMW-1:0] r_limit;
    t_ctl           w_ctl;
    t_row_st        w_st;
    logic           w_free, w_fire, w_prio;
    logic [LMW-1:0] w_lim;
    logic [NW-1:0]  w_lim_n, w_fill_n, w_batch;

    function automatic logic [OW-1:0] occ5(input logic [CW-1:0] f);
        logic [NW-1:0] t;
        t = NW'(f);
        return t[OW-1:0];
    endfunction

    function automatic t_res res_none(input logic [SW-1:0] st, input logic [CW-1:0] f);
        t_res r;
        r = '0;
        r.status = st;
        r.last   = 1'b1;
        r.occ    = occ5(f);
        return r;
    endfunction

    tcpq_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_st    (w_st)
    );

    assign w_free      = !r_rvld || i_res_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_free;
    assign w_fire      = i_cmd_valid && o_cmd_ready;
    assign w_prio      = (i_age >= r_senior) || i_health_worker;

    // batch size: limit clamped to 1..MAXRES, then to the fill
    always_comb begin
        priority if (r_limit == '0) begin
            w_lim = LMW'(1);
        end else if (LW'(r_limit) > LW'(MAXRES)) begin
            w_lim = LMW'(MAXRES);
        end else begin
            w_lim = r_limit;
        end
    end
    assign w_lim_n  = NW'(w_lim);
    assign w_fill_n = NW'(r_fill);
    assign w_batch  = (w_lim_n < w_fill_n) ? w_lim_n : w_fill_n;

    // sequencing of the row and the result register
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_left       = r_left;
        n_key        = r_key;
        n_rvld       = r_rvld && !i_res_ready;
        n_res        = r_res;
        w_ctl.op     = OP_HOLD;
        w_ctl.ins_prio = w_prio;
        w_ctl.ent    = '{vld: 1'b1, prio: w_prio, tkt: i_ticket, age: i_age};
        w_ctl.key    = r_key;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    unique case (i_action)
                        ACT_ENQ: begin
                            n_rvld = 1'b1;
                            if (r_fill == CW'(DEPTH)) begin
                                n_res = res_none(ST_FULL, r_fill);
                            end else begin
                                w_ctl.op = OP_INS;
                                n_fill   = r_fill + 1'b1;
                                n_res    = res_none(ST_OK, r_fill + 1'b1);
                            end
                        end
                        ACT_DEQ, ACT_SERVE: begin
                            if (r_fill == '0) begin
                                n_rvld = 1'b1;
                                n_res  = res_none(ST_EMPTY, r_fill);
                            end else begin
                                n_left  = (i_action == ACT_DEQ) ? LW'(1) : w_batch[LW-1:0];
                                n_state = S_POP;
                            end
                        end
                        ACT_PROMOTE: begin
                            if (r_fill == '0) begin
                                n_rvld = 1'b1;
                                n_res  = res_none(ST_EMPTY, r_fill);
                            end else begin
                                w_ctl.op = OP_START;
                                n_key    = i_ticket;
                                n_state  = S_SCAN;
                            end
                        end
                        ACT_ALL: begin
                            n_rvld = 1'b1;
                            if (r_fill == '0) begin
                                n_res = res_none(ST_EMPTY, r_fill);
                            end else begin
                                w_ctl.op = OP_MARK_ALL;
                                n_res    = res_none(ST_OK, r_fill);
                            end
                        end
                        default: begin
                            n_rvld = 1'b1;
                            n_res  = res_none(ST_OK, r_fill);
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_free) begin
                    w_ctl.op    = OP_POP;
                    n_rvld      = 1'b1;
                    n_res       = res_none(ST_OK, r_fill - 1'b1);
                    n_res.ovld  = 1'b1;
                    n_res.tkt   = w_st.head.tkt;
                    n_res.age   = w_st.head.age;
                    n_res.prio  = w_st.head.prio;
                    n_res.last  = (r_left == LW'(1));
                    n_fill      = r_fill - 1'b1;
                    n_left      = r_left - 1'b1;
                    if (r_left == LW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                priority if (w_st.hit) begin
                    n_state = S_BUBBLE;
                end else if (w_st.stop) begin
                    n_rvld  = 1'b1;
                    n_res   = res_none(ST_NOTFOUND, r_fill);
                    n_state = S_IDLE;
                end else begin
                    w_ctl.op = OP_SCAN;
                end
            end
            S_BUBBLE: begin
                if (w_st.tok0) begin
                    w_ctl.op = OP_MARK_HEAD;
                    n_rvld   = 1'b1;
                    n_res    = res_none(ST_OK, r_fill);
                    n_state  = S_IDLE;
                end else begin
                    w_ctl.op = OP_SWAP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, counters, result register, search key and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_left   <= '0;
            r_key    <= '0;
            r_rvld   <= 1'b0;
            r_res    <= '0;
            r_senior <= SENIOR_RST;
            r_limit  <= LIMIT_RST;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_key   <= n_key;
            r_rvld  <= n_rvld;
            r_res   <= n_res;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SENIOR: r_senior <= i_cfg_data[AW-1:0];
                    CFG_LIMIT:  r_limit  <= i_cfg_data[LMW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_res_valid    = r_rvld;
    assign o_status       = r_res.status;
    assign o_out_valid    = r_res.ovld;
    assign o_out_ticket   = r_res.tkt;
    assign o_out_age      = r_res.age;
    assign o_out_priority = r_res.prio;
    assign o_last         = r_res.last;
    assign o_occupancy    = r_res.occ;

endmodule

`default_nettype wire

// ----- sv/tcpq_checker.sv -----
`default_nettype none

module tcpq_checker (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     o_cmd_ready,
    input  wire logic                     o_res_valid,
    input  wire logic                     i_res_ready,
    input  wire logic [tcpq_pkg::SW-1:0]  o_status,
    input  wire logic                     o_out_valid,
    input  wire logic [tcpq_pkg::TW-1:0]  o_out_ticket,
    input  wire logic [tcpq_pkg::AW-1:0]  o_out_age,
    input  wire logic                     o_out_priority,
    input  wire logic                     o_last,
    input  wire logic [tcpq_pkg::OW-1:0]  o_occupancy
);
    import tcpq_pkg::*;

    // a waiting result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result dropped while stalled");

    // a popped entry always comes with ok status
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_out_valid |-> o_status == ST_OK)
        else $error("popped entry with error status");

    // a result without a pop ends its command and carries no entry
    a_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_out_valid |->
            o_last && o_out_ticket == '0 && o_out_age == '0 && !o_out_priority)
        else $error("non-pop result malformed");

    // no new command while a serve batch is still being delivered
    a_batch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_out_valid && !o_last && i_res_ready |-> !o_cmd_ready)
        else $error("command taken during a batch");

    // a popped entry cannot leave a full queue behind
    a_pop_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_out_valid |-> o_occupancy != OW'(DEPTH))
        else $error("occupancy after pop out of range");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (.*);

`default_nettype wire
